@@ hw/rtl/rpc_pkg.sv @@
// Shared types, widths and constants for the reference phase compensation block.
// Holds the stored reference phase table, the CORDIC angle table and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpc_pkg;

  localparam int REF_TABLE_DEPTH = 100;
  localparam int CORDIC_STAGES   = 16;
  localparam int TRIG_WIDTH      = 16;

  localparam int ROM_ENTRIES = 100;
  localparam int ROM_LIMIT   = (REF_TABLE_DEPTH < ROM_ENTRIES) ? REF_TABLE_DEPTH : ROM_ENTRIES;

  localparam int PHASE_W = 13;
  localparam int IDX_W   = 7;
  localparam int COMP_W  = 14;
  localparam int MAG_W   = COMP_W;
  localparam int PROD_W  = 32;           // mag * 268435
  localparam int N_W     = 22;           // mag * 456 + 500
  localparam int REC_W   = 23;           // reciprocal of 1000
  localparam int RECIP_SHIFT = 32;
  localparam int Q_W     = N_W + REC_W - RECIP_SHIFT;
  localparam int ANG_W   = 32;
  localparam int Z_W     = 32;           // signed Q28 angle
  localparam int XY_W    = 33;           // signed Q30 vector
  localparam int STAGE_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam int TRIG_SHIFT = 31 - TRIG_WIDTH;
  localparam int FRONT_STAGES = 7;

  // mag * 2^28 / 1000 = mag * 268435 + mag * 456 / 1000
  localparam logic [18:0] MUL_HI    = 19'd268435;
  localparam logic [8:0]  MUL_LO    = 9'd456;
  localparam logic [8:0]  HALF_K    = 9'd500;
  localparam logic [REC_W-1:0] RECIP_1000 = 23'd4294968;  // ceil(2^32 / 1000), exact for N_W bits

  localparam logic [ANG_W-1:0] TWO_PI_U = 32'd1686629713;
  localparam logic [ANG_W-1:0] PI_U     = 32'd843314857;
  localparam logic signed [Z_W-1:0] TWO_PI_Q28   = 32'sd1686629713;
  localparam logic signed [Z_W-1:0] PI_Q28       = 32'sd843314857;
  localparam logic signed [Z_W-1:0] HALF_PI_Q28  = 32'sd421657428;
  localparam logic signed [Z_W-1:0] NHALF_PI_Q28 = -32'sd421657428;
  localparam logic signed [XY_W-1:0] GAIN_Q30    = 33'sd652032874;

  localparam int PHASE_ROM [0:ROM_ENTRIES-1] = '{
    1813, -2271, -2049, -1714, 12, -1104, -1466, -3022, -2202, 2521,
    1486, -189, 46, -2301, 1757, -450, 2909, 2494, -315, 1236,
    1802, -353, -3008, -1789, 2335, -2636, -215, -397, 1913, -1199,
    -2851, -2066, 1692, 576, 175, 1209, -939, 2758, -871, 2429,
    2399, 760, -1463, 567, 1222, -1413, 2748, 276, 2615, -1408,
    1766, -691, 1478, 2717, 1355, -2688, 906, 1914, -892, 1761,
    -2627, 1737, 301, -1278, -575, -246, -2783, 184, 404, -3108,
    -1867, -324, 2636, 2782, -432, -38, -2088, -801, 1024, -707,
    2998, -2870, 232, 1262, -1965, -118, -72, 1156, -1922, 2807,
    -2163, 3122, -3011, -3088, -1974, -559, -410, -2112, -2573, -1422
  };

  typedef struct packed {
    logic                     flip;
    logic signed [COMP_W-1:0] phase;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
  } cord_t;

  typedef struct packed {
    logic  vld;
    cord_t d;
  } cell_bus_t;

  function automatic logic signed [PHASE_W-1:0] ref_phase(input logic [IDX_W-1:0] idx);
    logic signed [PHASE_W-1:0] v;
    v = '0;
    if (int'(idx) < ROM_LIMIT) begin
      v = PHASE_W'(PHASE_ROM[idx]);
    end
    return v;
  endfunction

  // atan(2^-i) in Q28, rounded to nearest
  function automatic logic signed [Z_W-1:0] stage_angle(input logic [STAGE_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (int'(i))
      0:       v = 32'sd210828714;
      1:       v = 32'sd124459457;
      2:       v = 32'sd65760959;
      3:       v = 32'sd33381290;
      4:       v = 32'sd16755422;
      5:       v = 32'sd8385879;
      6:       v = 32'sd4193963;
      7:       v = 32'sd2097109;
      8:       v = 32'sd1048571;
      9:       v = 32'sd524287;
      10:      v = 32'sd262144;
      11:      v = 32'sd131072;
      12:      v = 32'sd65536;
      13:      v = 32'sd32768;
      14:      v = 32'sd16384;
      15:      v = 32'sd8192;
      16:      v = 32'sd4096;
      17:      v = 32'sd2048;
      18:      v = 32'sd1024;
      19:      v = 32'sd512;
      20:      v = 32'sd256;
      21:      v = 32'sd128;
      22:      v = 32'sd64;
      23:      v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rpc_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on rpc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rpc_in_if import rpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PHASE_W-1:0] received_phase;
  logic        [IDX_W-1:0]   ref_index;

  modport source (output valid, output received_phase, output ref_index, input ready);
  modport sink   (input valid, input received_phase, input ref_index, output ready);
endinterface

interface rpc_out_if import rpc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COMP_W-1:0]     comp_phase;
  logic signed [TRIG_WIDTH-1:0] comp_cos;
  logic signed [TRIG_WIDTH-1:0] comp_sin;

  modport source (output valid, output comp_phase, output comp_cos, output comp_sin,
                  input ready);
  modport sink   (input valid, input comp_phase, input comp_cos, input comp_sin,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rpc_front.sv @@
// Front pipeline: table lookup, phase difference, milliradian to Q28 conversion,
// range reduction and quadrant fold. Feeds the first CORDIC cell.
// Depends on rpc_pkg and rpc_if.
`timescale 1ns / 1ps
`default_nettype none

module rpc_front import rpc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  rpc_in_if.sink     sample,
  input  wire logic  adv_next,
  output cell_bus_t  dn
);

  logic [FRONT_STAGES:1] vld;
  logic [FRONT_STAGES:1] adv;

  // stage registers
  logic signed [COMP_W-1:0] comp1, comp2, comp3, comp4, comp5, comp6, comp7;
  logic                     neg2, neg3, neg4, neg5;
  logic [PROD_W-1:0]        p2, p3;
  logic [N_W-1:0]           n2;
  logic [Q_W-1:0]           q3;
  logic [ANG_W-1:0]         a4, a5;
  logic signed [Z_W-1:0]    z6, z7;
  logic                     flip7;

  always_comb begin
    adv[FRONT_STAGES] = !vld[FRONT_STAGES] || adv_next;
    for (int k = FRONT_STAGES - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign sample.ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= sample.valid;
      for (int k = 2; k <= FRONT_STAGES; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // combinational terms
  logic signed [PHASE_W-1:0]   stored;
  logic [MAG_W-1:0]            mag;
  logic [N_W+REC_W-1:0]        qprod;
  logic [ANG_W-1:0]            a5_next;
  logic signed [Z_W-1:0]       as5, w_lo, w_hi, z6_next, z7_next;
  logic                        flip7_next;

  assign stored = ref_phase(sample.ref_index);
  assign mag    = comp1[COMP_W-1] ? MAG_W'(-comp1) : MAG_W'(comp1);
  assign qprod  = (N_W+REC_W)'(n2) * (N_W+REC_W)'(RECIP_1000);

  assign a5_next = (a4 >= TWO_PI_U) ? a4 - TWO_PI_U : a4;

  // wrap to (-pi, pi] and apply the sign; all four candidates in parallel
  assign as5  = Z_W'(a5);
  assign w_lo = neg5 ? -as5 : as5;
  assign w_hi = neg5 ? TWO_PI_Q28 - as5 : as5 - TWO_PI_Q28;
  assign z6_next = (a5 > PI_U) ? w_hi : w_lo;

  always_comb begin
    z7_next    = z6;
    flip7_next = 1'b0;
    if (z6 > HALF_PI_Q28) begin
      z7_next    = z6 - PI_Q28;
      flip7_next = 1'b1;
    end else if (z6 < NHALF_PI_Q28) begin
      z7_next    = z6 + PI_Q28;
      flip7_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      comp1 <= COMP_W'(stored) - COMP_W'(sample.received_phase);
    end
    if (adv[2]) begin
      comp2 <= comp1;
      neg2  <= comp1[COMP_W-1];
      p2    <= PROD_W'(mag) * PROD_W'(MUL_HI);
      n2    <= N_W'(mag) * N_W'(MUL_LO) + N_W'(HALF_K);
    end
    if (adv[3]) begin
      comp3 <= comp2;
      neg3  <= neg2;
      p3    <= p2;
      q3    <= qprod[RECIP_SHIFT +: Q_W];
    end
    if (adv[4]) begin
      comp4 <= comp3;
      neg4  <= neg3;
      a4    <= p3 + ANG_W'(q3);
    end
    if (adv[5]) begin
      comp5 <= comp4;
      neg5  <= neg4;
      a5    <= a5_next;
    end
    if (adv[6]) begin
      comp6 <= comp5;
      z6    <= z6_next;
    end
    if (adv[7]) begin
      comp7 <= comp6;
      z7    <= z7_next;
      flip7 <= flip7_next;
    end
  end

  assign dn.vld     = vld[FRONT_STAGES];
  assign dn.d.flip  = flip7;
  assign dn.d.phase = comp7;
  assign dn.d.x     = GAIN_Q30;
  assign dn.d.y     = '0;
  assign dn.d.z     = z7;

endmodule

`default_nettype wire

@@ hw/rtl/rpc_cell.sv @@
// One CORDIC rotation cell: a single micro-rotation and its pipeline register.
// Depends on rpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpc_cell import rpc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [STAGE_W-1:0] stage,
  input  wire cell_bus_t          up,
  input  wire logic               adv_next,
  output logic                    adv,
  output cell_bus_t               dn
);

  logic  vld;
  cord_t data;
  cord_t data_next;

  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  ang;

  assign adv = !vld || adv_next;

  assign dx  = up.d.y >>> stage;
  assign dy  = up.d.x >>> stage;
  assign ang = stage_angle(stage);

  always_comb begin
    data_next = up.d;
    if (!up.d.z[Z_W-1]) begin
      data_next.x = up.d.x - dx;
      data_next.y = up.d.y + dy;
      data_next.z = up.d.z - ang;
    end else begin
      data_next.x = up.d.x + dx;
      data_next.y = up.d.y - dy;
      data_next.z = up.d.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= up.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data <= data_next;
    end
  end

  assign dn.vld = vld;
  assign dn.d   = data;

endmodule

`default_nettype wire

@@ hw/rtl/reference_phase_compensation_sincos.sv @@
// Top level: front pipeline, row of CORDIC cells and rounded, saturated output register.
// Depends on rpc_pkg, rpc_if, rpc_front and rpc_cell.
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per clock unless back-pressure from the result side stalls the chain,
// and returns one result per item, in order. The path has seven front stages for
// lookup, scaling and range reduction, one CORDIC cell per iteration, and the output
// register. Every stage holds its item while the next one is full and cannot advance,
// so empty stages close up under back-pressure; ready ripples back through that chain.

module reference_phase_compensation_sincos import rpc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  rpc_in_if.sink    sample,
  rpc_out_if.source result
);

  localparam logic signed [XY_W:0] RND     = (XY_W+1)'(1) <<< (TRIG_SHIFT - 1);
  localparam logic signed [XY_W:0] RND_P1  = RND + (XY_W+1)'(1);
  localparam logic signed [XY_W:0] TRIG_HI = (XY_W+1)'((1 << (TRIG_WIDTH - 1)) - 1);
  localparam logic signed [XY_W:0] TRIG_LO = -TRIG_HI - (XY_W+1)'(1);

  cell_bus_t chain [0:CORDIC_STAGES];
  logic      adv_chain [0:CORDIC_STAGES];

  logic                         out_vld;
  logic                         adv_out;
  logic signed [COMP_W-1:0]     out_phase;
  logic signed [TRIG_WIDTH-1:0] out_cos, out_sin;

  // negate on flip folded into the rounding add: -v + r = ~v + r + 1
  function automatic logic signed [TRIG_WIDTH-1:0] to_trig(input logic signed [XY_W-1:0] v,
                                                           input logic flip);
    logic signed [XY_W:0] ve, s, r;
    ve = (XY_W+1)'(v);
    s  = flip ? (~ve + RND_P1) : (ve + RND);
    r  = s >>> TRIG_SHIFT;
    if (r > TRIG_HI) begin
      r = TRIG_HI;
    end else if (r < TRIG_LO) begin
      r = TRIG_LO;
    end
    return r[TRIG_WIDTH-1:0];
  endfunction

  rpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .adv_next (adv_chain[0]),
    .dn       (chain[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    rpc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .stage    (STAGE_W'(k)),
      .up       (chain[k]),
      .adv_next (adv_chain[k+1]),
      .adv      (adv_chain[k]),
      .dn       (chain[k+1])
    );
  end

  assign adv_out                  = !out_vld || result.ready;
  assign adv_chain[CORDIC_STAGES] = adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv_out) begin
      out_vld <= chain[CORDIC_STAGES].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_phase <= chain[CORDIC_STAGES].d.phase;
      out_cos   <= to_trig(chain[CORDIC_STAGES].d.x, chain[CORDIC_STAGES].d.flip);
      out_sin   <= to_trig(chain[CORDIC_STAGES].d.y, chain[CORDIC_STAGES].d.flip);
    end
  end

  assign result.valid      = out_vld;
  assign result.comp_phase = out_phase;
  assign result.comp_cos   = out_cos;
  assign result.comp_sin   = out_sin;

endmodule

`default_nettype wire

@@ tb/phase_comp_checker.sv @@
// Checker for the reference phase compensation block: watches both channels,
// predicts each result from the accepted sample and compares it field by field.
// Depends on rpc_pkg for widths and on rpc_if for the channel interfaces.
`timescale 1ns / 1ps

module phase_comp_checker import rpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  rpc_in_if    in_ch,
  rpc_out_if   out_ch,
  output int   errors,
  output int   pending
);

  localparam longint RAD_ONE_Q28   = 64'sd268435456;
  localparam longint PI_MRAD_Q28   = 64'sd843314857;
  localparam longint TWO_PI_MRAD   = 64'sd1686629713;
  localparam longint HALF_PI_MRAD  = 64'sd421657428;
  localparam longint QUARTER_PI    = 64'sd210828714;
  localparam longint CORDIC_GAIN   = 64'sd652032874;
  localparam int     ROUND_SHIFT   = 31 - TRIG_WIDTH;

  // stored reference phases, milliradians
  localparam int STORED_MRAD [0:99] = '{
    1813, -2271, -2049, -1714, 12, -1104, -1466, -3022, -2202, 2521,
    1486, -189, 46, -2301, 1757, -450, 2909, 2494, -315, 1236,
    1802, -353, -3008, -1789, 2335, -2636, -215, -397, 1913, -1199,
    -2851, -2066, 1692, 576, 175, 1209, -939, 2758, -871, 2429,
    2399, 760, -1463, 567, 1222, -1413, 2748, 276, 2615, -1408,
    1766, -691, 1478, 2717, 1355, -2688, 906, 1914, -892, 1761,
    -2627, 1737, 301, -1278, -575, -246, -2783, 184, 404, -3108,
    -1867, -324, 2636, 2782, -432, -38, -2088, -801, 1024, -707,
    2998, -2870, 232, 1262, -1965, -118, -72, 1156, -1922, 2807,
    -2163, 3122, -3011, -3088, -1974, -559, -410, -2112, -2573, -1422
  };

  typedef struct {
    logic signed [COMP_W-1:0]     phase;
    logic signed [TRIG_WIDTH-1:0] cos_q;
    logic signed [TRIG_WIDTH-1:0] sin_q;
  } trig_result_t;

  trig_result_t expected_trig_q[$];
  trig_result_t want;
  longint       atan_q28 [0:CORDIC_STAGES-1];

  // atan(2^-i) in Q28 from the odd power series, worked in Q60
  function automatic longint atan_pow2(input int i);
    longint acc;
    longint term;
    int     k;
    int     e;
    if (i == 0) return QUARTER_PI;
    acc = 0;
    for (k = 0; i * (2 * k + 1) < 60; k++) begin
      e = i * (2 * k + 1);
      term = (64'sd1 <<< (60 - e)) / longint'(2 * k + 1);
      acc = (k % 2 == 1) ? acc - term : acc + term;
    end
    return (acc + (64'sd1 <<< 31)) >>> 32;
  endfunction

  function automatic logic signed [TRIG_WIDTH-1:0] to_trig(input longint v);
    longint r;
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (TRIG_WIDTH - 1)) - 1;
    lo = -(64'sd1 <<< (TRIG_WIDTH - 1));
    r = (v + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[TRIG_WIDTH-1:0];
  endfunction

  function automatic trig_result_t compensate(input logic signed [PHASE_W-1:0] rx,
                                              input logic [IDX_W-1:0] idx);
    trig_result_t res;
    longint stored;
    longint diff;
    longint mag;
    longint ang;
    longint x;
    longint y;
    longint nx;
    bit     flip;
    int     i;
    stored = (int'(idx) < 100 && int'(idx) < REF_TABLE_DEPTH) ? STORED_MRAD[idx] : 0;
    diff = stored - longint'(rx);
    mag = (diff < 0) ? -diff : diff;
    ang = (mag * RAD_ONE_Q28 + 500) / 1000;
    ang = ang % TWO_PI_MRAD;
    if (ang > PI_MRAD_Q28) ang = ang - TWO_PI_MRAD;
    if (diff < 0) ang = -ang;
    // fold into the right half-plane; outputs are negated afterwards
    flip = 1'b0;
    if (ang > HALF_PI_MRAD) begin
      ang = ang - PI_MRAD_Q28;
      flip = 1'b1;
    end else if (ang < -HALF_PI_MRAD) begin
      ang = ang + PI_MRAD_Q28;
      flip = 1'b1;
    end
    x = CORDIC_GAIN;
    y = 0;
    for (i = 0; i < CORDIC_STAGES; i++) begin
      if (ang >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        ang = ang - atan_q28[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        ang = ang + atan_q28[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    res.phase = diff[COMP_W-1:0];
    res.cos_q = to_trig(x);
    res.sin_q = to_trig(y);
    return res;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) atan_q28[i] = atan_pow2(i);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        expected_trig_q.push_back(compensate(in_ch.received_phase, in_ch.ref_index));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_trig_q.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: result with nothing expected: phase %0d cos %0d sin %0d",
                   $time, out_ch.comp_phase, out_ch.comp_cos, out_ch.comp_sin);
        end else begin
          want = expected_trig_q.pop_front();
          if (out_ch.comp_phase !== want.phase || out_ch.comp_cos !== want.cos_q ||
              out_ch.comp_sin !== want.sin_q) begin
            errors <= errors + 1;
            $display("%0t: mismatch: expected phase %0d cos %0d sin %0d, got %0d %0d %0d",
                     $time, want.phase, want.cos_q, want.sin_q,
                     out_ch.comp_phase, out_ch.comp_cos, out_ch.comp_sin);
          end
        end
      end
      pending <= expected_trig_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the reference phase compensation testbench: clock, reset, sample stimulus,
// result back-pressure and the verdict. Depends on rpc_pkg, rpc_if, the block and
// phase_comp_checker.
`timescale 1ns / 1ps

module tb_top import rpc_pkg::*;;

  localparam int RANDOM_SAMPLES = 1830;
  localparam int CALM_TAIL      = 200;
  localparam int DRAIN_CYCLES   = FRONT_STAGES + CORDIC_STAGES + 1 + 16;
  localparam int CYCLE_LIMIT    = 400000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles;
  int   gap_pct;
  int   stall_pct;
  int   stall_left;
  bit   calm;
  int   sent;
  int   beyond_table;
  int   off_nominal;

  // phase differences that sit on the quadrant and wrap boundaries
  int corner_mrad [0:8] = '{0, 1571, -1571, 3142, -3142, 4712, -4712, 6283, -6283};

  rpc_in_if  sample_ch ();
  rpc_out_if result_ch ();

  reference_phase_compensation_sincos u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch.sink),
    .result (result_ch.source)
  );

  phase_comp_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (sample_ch),
    .out_ch  (result_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped at cycle %0d with %0d results outstanding", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      result_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_sample(input int rx, input int idx);
    int gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 4);
      sample_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid          = 1'b1;
    sample_ch.received_phase = PHASE_W'(rx);
    sample_ch.ref_index      = IDX_W'(idx);
    sent++;
    if (idx >= 100) beyond_table++;
    if (rx < -3142 || rx > 3141) off_nominal++;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    int idx;
    int rx;
    int pick;
    int stored;
    idx = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 99) : $urandom_range(100, 127);
    pick = $urandom_range(0, 99);
    rx = $urandom_range(0, 8191) - 4096;
    if (pick < 65) begin
      rx = $urandom_range(0, 6283) - 3142;
    end else if (pick >= 80) begin
      stored = (idx < 100) ? PHASE_ROM[idx] : 0;
      pick = stored - (corner_mrad[$urandom_range(0, 8)] + $urandom_range(0, 8) - 4);
      if (pick >= -4096 && pick <= 4095) rx = pick;
    end
    send_sample(rx, idx);
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 45;
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    cycles = 0;
    calm = 1'b0;
    gap_pct = 30;
    stall_pct = 30;
    stall_left = 0;
    sent = 0;
    beyond_table = 0;
    off_nominal = 0;
    sample_ch.valid = 1'b0;
    sample_ch.received_phase = '0;
    sample_ch.ref_index = '0;
    result_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero difference, field extremes, quadrant and wrap boundaries
    send_sample(12, 4);
    send_sample(-1422, 99);
    send_sample(0, 100);
    send_sample(0, 127);
    send_sample(-4096, 0);
    send_sample(4095, 7);
    send_sample(-3142, 91);
    send_sample(3141, 69);
    send_sample(-4096, 16);
    send_sample(4095, 69);
    send_sample(-1571, 127);
    send_sample(1571, 127);
    send_sample(-1570, 120);
    send_sample(1572, 110);
    send_sample(-3142, 100);
    send_sample(3142, 100);
    send_sample(-3141, 101);
    send_sample(-1, 127);
    send_sample(1, 127);
    send_sample(-4096, 127);
    send_sample(4095, 127);
    send_sample(-2730, 85);
    send_sample(2730, 2);

    // hold off until the pipeline has emptied
    sample_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);

    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      if (n % 150 == 0) begin
        gap_pct = pick_pct();
        stall_pct = pick_pct();
      end
      if (n == RANDOM_SAMPLES / 2) begin
        sample_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      if (n == RANDOM_SAMPLES - CALM_TAIL) calm = 1'b1;
      send_random();
    end

    sample_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d samples sent over all bits of both fields, %0d past the table end,",
             sent, beyond_table);
    $display("%0d outside the nominal phase range, with bursty idling on both sides",
             off_nominal);
    if (errors == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/rpc_pkg.sv
hw/rtl/rpc_if.sv
hw/rtl/rpc_front.sv
hw/rtl/rpc_cell.sv
hw/rtl/reference_phase_compensation_sincos.sv
tb/phase_comp_checker.sv
tb/tb_top.sv
